[rtl/pflp_pkg.sv]
// ----------------------------------------------------------------------------
// Pet fountain controller package
// Shared types, constants and helper functions for the pet fountain level,
// pump and clock-setting controller.
// ----------------------------------------------------------------------------
package pflp_pkg;

  localparam int LEVEL_BITS  = 12;
  localparam int DIGIT_COUNT = 12;
  localparam int DIGIT_BITS  = 4;
  localparam int CURSOR_BITS = 4;
  localparam int PAIR_BITS   = 7;
  localparam int PAIR_COUNT  = DIGIT_COUNT / 2;
  localparam int TOTAL_BITS  = 32;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_DRINK  = 3'd1,
    MODE_LOW    = 3'd2,
    MODE_EMPTY  = 3'd3,
    MODE_CLOCK  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    IND_NORMAL = 2'd0,
    IND_LOW    = 2'd1,
    IND_EMPTY  = 2'd2
  } indicator_t;

  // Register indexes on the configuration port (byte address / 4).
  typedef enum logic [1:0] {
    REG_EMPTY_THR       = 2'd0,
    REG_LOW_THR         = 2'd1,
    REG_LEAVE_LOW_THR   = 2'd2,
    REG_LEAVE_EMPTY_THR = 2'd3
  } reg_index_t;

  typedef logic [LEVEL_BITS-1:0]  level_t;
  typedef logic [DIGIT_BITS-1:0]  digit_t;
  typedef logic [CURSOR_BITS-1:0] cursor_t;
  typedef logic [PAIR_BITS-1:0]   pair_t;
  typedef logic [TOTAL_BITS-1:0]  total_t;

  // Return target after drinking or clock setting; only low and empty are
  // kept, anything else falls back to normal.
  function automatic mode_t valid_return(input mode_t m);
    mode_t r;
    r = MODE_NORMAL;
    if (m == MODE_LOW || m == MODE_EMPTY) begin
      r = m;
    end
    return r;
  endfunction

  // Digit step modulo ten.
  function automatic digit_t digit_step(input digit_t d);
    logic [DIGIT_BITS:0] s;
    s = {1'b0, d} + 5'd1;
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[DIGIT_BITS-1:0];
  endfunction

  // Two decimal digits into one value: first * 10 + second, kept to 7 bits.
  function automatic pair_t digit_pair(input digit_t hi, input digit_t lo);
    logic [7:0] v;
    v = ({4'd0, hi} << 3) + ({4'd0, hi} << 1) + {4'd0, lo};
    return v[PAIR_BITS-1:0];
  endfunction

endpackage

[rtl/pflp_in_if.sv]
// ----------------------------------------------------------------------------
// Pet fountain sample channel
// Valid/ready channel that carries one tick: level sample, cat flag, buttons.
// ----------------------------------------------------------------------------
interface pflp_in_if;
  import pflp_pkg::*;

  logic   valid;
  logic   ready;
  level_t level_sample;
  logic   cat_near;
  logic   button_step;
  logic   button_next;

  modport source (output valid, output level_sample, output cat_near,
                  output button_step, output button_next, input ready);
  modport sink   (input valid, input level_sample, input cat_near,
                  input button_step, input button_next, output ready);
endinterface

[rtl/pflp_out_if.sv]
// ----------------------------------------------------------------------------
// Pet fountain result channel
// Valid/ready channel that carries the controller status after one tick.
// ----------------------------------------------------------------------------
interface pflp_out_if;
  import pflp_pkg::*;

  logic          valid;
  logic          ready;
  logic [2:0]    mode;
  logic          pump_on;
  logic [1:0]    level_indicator;
  total_t        drunk_total;
  cursor_t       cursor_position;
  logic          time_commit;
  pair_t         seconds_value;
  pair_t         minutes_value;
  pair_t         hours_value;
  pair_t         day_value;
  pair_t         month_value;
  pair_t         year_value;

  modport source (output valid, output mode, output pump_on, output level_indicator,
                  output drunk_total, output cursor_position, output time_commit,
                  output seconds_value, output minutes_value, output hours_value,
                  output day_value, output month_value, output year_value,
                  input ready);
  modport sink   (input valid, input mode, input pump_on, input level_indicator,
                  input drunk_total, input cursor_position, input time_commit,
                  input seconds_value, input minutes_value, input hours_value,
                  input day_value, input month_value, input year_value,
                  output ready);
endinterface

[rtl/pet_fountain_level_pump_fsm.sv]
// ----------------------------------------------------------------------------
// Pet fountain level and pump controller
// Mode machine with level hysteresis, pump drive, drunk-volume total and
// clock-digit editing, one tick per transfer.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on in_chan is one tick: a level sample, the cat flag and the
// two buttons. For every tick the block returns exactly one transfer on
// out_chan with the mode, pump drive, level indication, drunk total, edit
// cursor and, on the tick that finishes clock setting, the six committed
// two-digit values (zero on all other ticks).
// The tick is evaluated in the cycle it is transferred: the mode registers
// and the result register load at that same edge, so a result appears in the
// cycle after its tick. One tick per cycle is sustained; the only limit is
// the single result register, which frees up in the cycle it is taken.
// When the receiver stalls, the result is held and in_chan.ready drops until
// the result is taken, so no tick is lost or duplicated.
// The user writes the four thresholds over the APB-style cfg_ port while no
// tick is in flight; the block does not enforce this. Reads return the
// stored 12-bit values. Synchronous active-low reset puts the block in normal
// mode with the pump off, the drunk total and all clock digits zero, and the
// thresholds at 400, 1000, 1200 and 600. The result register is then empty.
// ----------------------------------------------------------------------------
module pet_fountain_level_pump_fsm (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pflp_in_if.sink                              in_chan,
  pflp_out_if.source                           out_chan,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [pflp_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [pflp_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [pflp_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                 cfg_pready
);
  import pflp_pkg::*;

  // Threshold registers.
  level_t empty_thr_r, low_thr_r, leave_low_thr_r, leave_empty_thr_r;

  // Controller state.
  mode_t      mode_r, mode_nxt;
  mode_t      return_mode_r, return_mode_nxt;
  level_t     level_start_r, level_start_nxt;
  total_t     drunk_r, drunk_nxt;
  cursor_t    cursor_r, cursor_nxt;
  indicator_t ind_r, ind_nxt;
  logic       pump_r, pump_nxt;
  digit_t     digits_r [DIGIT_COUNT];
  logic       digit_we;
  digit_t     digit_wdata;
  logic       commit;

  // Result register.
  logic       out_valid_r;
  logic       res_commit_r;
  pair_t      res_pair_r [PAIR_COUNT];

  logic       accept;
  logic       cfg_write;
  reg_index_t cfg_index;
  level_t     level;
  logic [TOTAL_BITS:0] drunk_sum;
  level_t     drop;
  digit_t     cur_digit;

  assign cfg_pready = 1'b1;
  assign cfg_index  = reg_index_t'(cfg_paddr[CFG_ADDR_BITS-1:2]);
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;

  // The result register is a one-entry buffer: a new tick may be taken
  // whenever it is empty or being emptied in this cycle.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign level         = in_chan.level_sample;

  always_comb begin
    case (cfg_index)
      REG_EMPTY_THR:       cfg_prdata = {{(CFG_DATA_BITS-LEVEL_BITS){1'b0}}, empty_thr_r};
      REG_LOW_THR:         cfg_prdata = {{(CFG_DATA_BITS-LEVEL_BITS){1'b0}}, low_thr_r};
      REG_LEAVE_LOW_THR:   cfg_prdata = {{(CFG_DATA_BITS-LEVEL_BITS){1'b0}}, leave_low_thr_r};
      REG_LEAVE_EMPTY_THR: cfg_prdata = {{(CFG_DATA_BITS-LEVEL_BITS){1'b0}},
                                         leave_empty_thr_r};
      default:             cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_thr_r       <= LEVEL_BITS'(400);
      low_thr_r         <= LEVEL_BITS'(1000);
      leave_low_thr_r   <= LEVEL_BITS'(1200);
      leave_empty_thr_r <= LEVEL_BITS'(600);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EMPTY_THR:       empty_thr_r       <= cfg_pwdata[LEVEL_BITS-1:0];
        REG_LOW_THR:         low_thr_r         <= cfg_pwdata[LEVEL_BITS-1:0];
        REG_LEAVE_LOW_THR:   leave_low_thr_r   <= cfg_pwdata[LEVEL_BITS-1:0];
        REG_LEAVE_EMPTY_THR: leave_empty_thr_r <= cfg_pwdata[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Drop in level since drinking began, and the saturating sum.
  assign drop      = level_start_r - level;
  assign drunk_sum = {1'b0, drunk_r} + {{(TOTAL_BITS+1-LEVEL_BITS){1'b0}}, drop};

  // The cursor stays below the digit count in practice; guard the read anyway.
  assign cur_digit = (cursor_r < CURSOR_BITS'(DIGIT_COUNT))
                     ? digits_r[cursor_r] : '0;

  // Next state for one tick.
  always_comb begin
    mode_nxt        = mode_r;
    return_mode_nxt = return_mode_r;
    level_start_nxt = level_start_r;
    drunk_nxt       = drunk_r;
    cursor_nxt      = cursor_r;
    ind_nxt         = ind_r;
    pump_nxt        = pump_r;
    digit_we        = 1'b0;
    digit_wdata     = digit_step(cur_digit);
    commit          = 1'b0;

    case (mode_r)
      MODE_DRINK: begin
        if (!in_chan.cat_near) begin
          // Cat left: book any drop, stop the pump and go back.
          if (level < level_start_r) begin
            drunk_nxt = drunk_sum[TOTAL_BITS] ? '1 : drunk_sum[TOTAL_BITS-1:0];
          end
          pump_nxt = 1'b0;
          mode_nxt = valid_return(return_mode_r);
        end else if (level < empty_thr_r) begin
          pump_nxt = 1'b0;
          ind_nxt  = IND_EMPTY;
          mode_nxt = MODE_EMPTY;
        end
      end
      MODE_LOW: begin
        if (in_chan.button_next) begin
          cursor_nxt      = '0;
          return_mode_nxt = MODE_LOW;
          mode_nxt        = MODE_CLOCK;
        end else if (level <= empty_thr_r) begin
          ind_nxt  = IND_EMPTY;
          mode_nxt = MODE_EMPTY;
        end else if (level > leave_low_thr_r) begin
          ind_nxt  = IND_NORMAL;
          mode_nxt = MODE_NORMAL;
        end else if (in_chan.cat_near) begin
          pump_nxt        = 1'b1;
          return_mode_nxt = MODE_LOW;
          level_start_nxt = level;
          mode_nxt        = MODE_DRINK;
        end
      end
      MODE_EMPTY: begin
        if (in_chan.button_next) begin
          cursor_nxt      = '0;
          return_mode_nxt = MODE_EMPTY;
          mode_nxt        = MODE_CLOCK;
        end else if (level > leave_empty_thr_r) begin
          ind_nxt  = IND_LOW;
          mode_nxt = MODE_LOW;
        end else if (level > leave_low_thr_r) begin
          ind_nxt  = IND_NORMAL;
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_CLOCK: begin
        // Button A wins when both are pressed.
        if (in_chan.button_step) begin
          digit_we = (cursor_r < CURSOR_BITS'(DIGIT_COUNT));
        end else if (in_chan.button_next) begin
          if ({1'b0, cursor_r} + 5'd1 >= 5'(DIGIT_COUNT)) begin
            commit     = 1'b1;
            cursor_nxt = '0;
            mode_nxt   = valid_return(return_mode_r);
          end else begin
            cursor_nxt = cursor_r + CURSOR_BITS'(1);
          end
        end
      end
      default: begin
        // Normal mode; unused codes behave the same way.
        if (in_chan.button_next) begin
          cursor_nxt      = '0;
          return_mode_nxt = MODE_NORMAL;
          mode_nxt        = MODE_CLOCK;
        end else if (level < empty_thr_r) begin
          ind_nxt  = IND_EMPTY;
          mode_nxt = MODE_EMPTY;
        end else if (level < low_thr_r) begin
          ind_nxt  = IND_LOW;
          mode_nxt = MODE_LOW;
        end else if (in_chan.cat_near) begin
          pump_nxt        = 1'b1;
          return_mode_nxt = MODE_NORMAL;
          level_start_nxt = level;
          mode_nxt        = MODE_DRINK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_NORMAL;
      return_mode_r <= MODE_NORMAL;
      level_start_r <= '0;
      drunk_r       <= '0;
      cursor_r      <= '0;
      ind_r         <= IND_NORMAL;
      pump_r        <= 1'b0;
    end else if (accept) begin
      mode_r        <= mode_nxt;
      return_mode_r <= return_mode_nxt;
      level_start_r <= level_start_nxt;
      drunk_r       <= drunk_nxt;
      cursor_r      <= cursor_nxt;
      ind_r         <= ind_nxt;
      pump_r        <= pump_nxt;
    end
  end

  // Clock digits: reset value is zero, at most one digit written per tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digits_r[i] <= '0;
      end
    end else if (accept && digit_we) begin
      digits_r[cursor_r] <= digit_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: the state after the tick, plus committed values.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_commit_r <= commit;
      for (int p = 0; p < PAIR_COUNT; p++) begin
        res_pair_r[p] <= commit ? digit_pair(digits_r[2*p], digits_r[2*p+1]) : '0;
      end
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.mode            = mode_r;
  assign out_chan.pump_on         = pump_r;
  assign out_chan.level_indicator = ind_r;
  assign out_chan.drunk_total     = drunk_r;
  assign out_chan.cursor_position = cursor_r;
  assign out_chan.time_commit     = res_commit_r;
  assign out_chan.seconds_value   = res_pair_r[0];
  assign out_chan.minutes_value   = res_pair_r[1];
  assign out_chan.hours_value     = res_pair_r[2];
  assign out_chan.day_value       = res_pair_r[3];
  assign out_chan.month_value     = res_pair_r[4];
  assign out_chan.year_value      = res_pair_r[5];

endmodule

[test/tb_pet_fountain_level_pump_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pet fountain level and pump controller testbench
// Sends level/cat/button ticks over the sample channel, and drains the status
// channel under random stalls. Every status transfer is compared with a
// cycle-free model of the mode machine that the testbench keeps. The
// thresholds are rewritten over the APB-style port between phases.
// ----------------------------------------------------------------------------
module tb_pet_fountain_level_pump_fsm;
  import pflp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DIGIT_BASE  = 10;
  localparam int PHASES      = 6;
  localparam int PHASE_TICKS = 138;
  localparam int N_DIRECTED  = 25;

  // One tick as it goes into the block.
  typedef struct packed {
    level_t level;
    logic   cat;
    logic   step;
    logic   next;
  } tick_t;

  // One status transfer as the block returns it.
  typedef struct packed {
    mode_t                       mode;
    logic                        pump;
    indicator_t                  ind;
    total_t                      drunk;
    cursor_t                     cursor;
    logic                        commit;
    logic [PAIR_COUNT-1:0][PAIR_BITS-1:0] pairs;
  } status_t;

  // A row of the directed script. Where chk is set, the listed fields are
  // typed in by hand and take the place of the model's values.
  typedef struct packed {
    tick_t      t;
    logic       chk;
    mode_t      mode;
    logic       pump;
    indicator_t ind;
    cursor_t    cursor;
    logic       commit;
  } script_row_t;

  localparam logic [LEVEL_BITS-1:0] RESET_THR [4] = '{12'd400, 12'd1000, 12'd1200, 12'd600};

  // Directed script, run right after reset with the reset thresholds
  // (empty 400, low 1000, leave low 1200, leave empty 600).
  localparam script_row_t DIRECTED_TICKS [N_DIRECTED] = '{
    // Full tank, nobody around: normal mode stays.
    '{'{12'd4095, 1'b0, 1'b0, 1'b0}, 1'b1, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    // Cat arrives: pump starts, level 2000 is remembered.
    '{'{12'd2000, 1'b1, 1'b0, 1'b0}, 1'b1, MODE_DRINK,  1'b1, IND_NORMAL, 4'd0, 1'b0},
    // Cat leaves 500 lower: that drop goes into the total.
    '{'{12'd1500, 1'b0, 1'b0, 1'b0}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    // Bottom of the range: straight to empty.
    '{'{12'd0,    1'b0, 1'b0, 1'b0}, 1'b1, MODE_EMPTY,  1'b0, IND_EMPTY,  4'd0, 1'b0},
    '{'{12'd700,  1'b0, 1'b0, 1'b0}, 1'b1, MODE_LOW,    1'b0, IND_LOW,    4'd0, 1'b0},
    // Drinking from low mode.
    '{'{12'd500,  1'b1, 1'b0, 1'b0}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    // Tank runs dry while the cat is still there: pump stops, no total.
    '{'{12'd300,  1'b1, 1'b0, 1'b0}, 1'b1, MODE_EMPTY,  1'b0, IND_EMPTY,  4'd0, 1'b0},
    // With these thresholds, empty steps up to low first, even on a full reading.
    '{'{12'd4095, 1'b0, 1'b0, 1'b0}, 1'b1, MODE_LOW,    1'b0, IND_LOW,    4'd0, 1'b0},
    '{'{12'd1300, 1'b0, 1'b0, 1'b0}, 1'b1, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    '{'{12'd999,  1'b0, 1'b0, 1'b0}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    // Exactly at the empty threshold with a cat: empty wins over drinking.
    '{'{12'd400,  1'b1, 1'b0, 1'b0}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    // Button B from empty opens clock setting.
    '{'{12'd0,    1'b0, 1'b0, 1'b1}, 1'b1, MODE_CLOCK,  1'b0, IND_EMPTY,  4'd0, 1'b0},
    // Both buttons: the digit steps and the cursor stays put.
    '{'{12'd0,    1'b0, 1'b1, 1'b1}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    // Walk the cursor across all twelve digits; level and cat are ignored.
    '{'{12'd4095, 1'b1, 1'b0, 1'b1}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    '{'{12'd1234, 1'b0, 1'b0, 1'b1}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    '{'{12'd0,    1'b1, 1'b0, 1'b1}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    '{'{12'd2048, 1'b0, 1'b0, 1'b1}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    '{'{12'd1365, 1'b1, 1'b0, 1'b1}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    '{'{12'd2730, 1'b0, 1'b0, 1'b1}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    '{'{12'd4095, 1'b0, 1'b0, 1'b1}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    '{'{12'd1,    1'b1, 1'b0, 1'b1}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    '{'{12'd600,  1'b0, 1'b0, 1'b1}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    '{'{12'd3000, 1'b1, 1'b0, 1'b1}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    '{'{12'd100,  1'b0, 1'b0, 1'b1}, 1'b0, MODE_NORMAL, 1'b0, IND_NORMAL, 4'd0, 1'b0},
    // Button B on the last digit commits and goes back to empty mode.
    '{'{12'd4095, 1'b1, 1'b0, 1'b1}, 1'b1, MODE_EMPTY,  1'b0, IND_EMPTY,  4'd0, 1'b1}
  };

  logic clk = 1'b0;
  logic rst_n;

  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  pflp_in_if  tick_bus ();
  pflp_out_if status_bus ();

  pet_fountain_level_pump_fsm uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (tick_bus),
    .out_chan    (status_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // Model state: thresholds as last written, and the controller registers.
  level_t     thr_empty;
  level_t     thr_low;
  level_t     thr_leave_low;
  level_t     thr_leave_empty;
  mode_t      fm_mode;
  mode_t      fm_ret;
  level_t     fm_start_level;
  total_t     fm_drunk;
  cursor_t    fm_cursor;
  digit_t     fm_digits [DIGIT_COUNT];
  indicator_t fm_ind;
  logic       fm_pump;

  status_t pending_status [$];
  status_t front_status;
  int      mismatches = 0;
  int      ticks_sent = 0;
  int      cycle_count = 0;
  int      send_pct = 0;
  int      stall_pct = 0;

  // Works out the status after one tick and advances the model state.
  function automatic status_t predict_status(input tick_t t);
    status_t    s;
    logic [32:0] sum;
    int         v;
    s = '0;
    case (fm_mode)
      MODE_DRINK: begin
        if (!t.cat) begin
          // The cat left: only a fall in level counts, and the total sticks
          // at its maximum rather than wrapping.
          if (t.level < fm_start_level) begin
            sum = {1'b0, fm_drunk} + 33'(fm_start_level - t.level);
            fm_drunk = sum[32] ? '1 : sum[31:0];
          end
          fm_pump = 1'b0;
          fm_mode = (fm_ret == MODE_LOW || fm_ret == MODE_EMPTY) ? fm_ret : MODE_NORMAL;
        end else if (t.level < thr_empty) begin
          fm_pump = 1'b0;
          fm_ind  = IND_EMPTY;
          fm_mode = MODE_EMPTY;
        end
      end
      MODE_LOW: begin
        if (t.next) begin
          fm_cursor = '0;
          fm_ret    = MODE_LOW;
          fm_mode   = MODE_CLOCK;
        end else if (t.level <= thr_empty) begin
          fm_ind  = IND_EMPTY;
          fm_mode = MODE_EMPTY;
        end else if (t.level > thr_leave_low) begin
          fm_ind  = IND_NORMAL;
          fm_mode = MODE_NORMAL;
        end else if (t.cat) begin
          fm_pump        = 1'b1;
          fm_ret         = MODE_LOW;
          fm_start_level = t.level;
          fm_mode        = MODE_DRINK;
        end
      end
      MODE_EMPTY: begin
        if (t.next) begin
          fm_cursor = '0;
          fm_ret    = MODE_EMPTY;
          fm_mode   = MODE_CLOCK;
        end else if (t.level > thr_leave_empty) begin
          fm_ind  = IND_LOW;
          fm_mode = MODE_LOW;
        end else if (t.level > thr_leave_low) begin
          fm_ind  = IND_NORMAL;
          fm_mode = MODE_NORMAL;
        end
      end
      MODE_CLOCK: begin
        if (t.step) begin
          if (fm_cursor < DIGIT_COUNT) begin
            fm_digits[fm_cursor] = (fm_digits[fm_cursor] == digit_t'(DIGIT_BASE - 1)) ?
                                   '0 : fm_digits[fm_cursor] + 1'b1;
          end
        end else if (t.next) begin
          if (int'(fm_cursor) + 1 >= DIGIT_COUNT) begin
            s.commit = 1'b1;
            for (int k = 0; k < PAIR_COUNT; k++) begin
              v = int'(fm_digits[2*k]) * DIGIT_BASE + int'(fm_digits[2*k+1]);
              s.pairs[k] = pair_t'(v);
            end
            fm_cursor = '0;
            fm_mode   = (fm_ret == MODE_LOW || fm_ret == MODE_EMPTY) ? fm_ret : MODE_NORMAL;
          end else begin
            fm_cursor = fm_cursor + 1'b1;
          end
        end
      end
      default: begin
        if (t.next) begin
          fm_cursor = '0;
          fm_ret    = MODE_NORMAL;
          fm_mode   = MODE_CLOCK;
        end else if (t.level < thr_empty) begin
          fm_ind  = IND_EMPTY;
          fm_mode = MODE_EMPTY;
        end else if (t.level < thr_low) begin
          fm_ind  = IND_LOW;
          fm_mode = MODE_LOW;
        end else if (t.cat) begin
          fm_pump        = 1'b1;
          fm_ret         = MODE_NORMAL;
          fm_start_level = t.level;
          fm_mode        = MODE_DRINK;
        end
      end
    endcase
    s.mode   = fm_mode;
    s.pump   = fm_pump;
    s.ind    = fm_ind;
    s.drunk  = fm_drunk;
    s.cursor = fm_cursor;
    return s;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
      end
    end
  endtask

  // One APB transfer: setup cycle, access cycle, then idle, so that
  // back-to-back transfers never touch psel twice in one time step. Read
  // data is taken at the edge that closes the access cycle.
  task automatic apb_cycle(input bit wr, input reg_index_t idx,
                           input logic [CFG_DATA_BITS-1:0] wdata,
                           output logic [CFG_DATA_BITS-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Writes a threshold with junk in the unused upper bits, reads it back and
  // keeps the model in step.
  task automatic write_threshold(input reg_index_t idx, input level_t val);
    logic [CFG_DATA_BITS-1:0] rd;
    apb_cycle(1'b1, idx, {20'($urandom), val}, rd);
    apb_cycle(1'b0, idx, '0, rd);
    check_field("threshold readback", 32'(val), rd);
    case (idx)
      REG_EMPTY_THR:     thr_empty       = val;
      REG_LOW_THR:       thr_low         = val;
      REG_LEAVE_LOW_THR: thr_leave_low   = val;
      default:           thr_leave_empty = val;
    endcase
  endtask

  // Presents one tick, holds it until the transfer and then records what the
  // block must answer. Idle gaps come before the tick, never after, so valid
  // is only ever raised or lowered once per time step.
  task automatic send_tick(input script_row_t r);
    status_t s;
    while ($urandom_range(99) < send_pct) begin
      tick_bus.valid <= 1'b0;
      @(posedge clk);
    end
    tick_bus.valid        <= 1'b1;
    tick_bus.level_sample <= r.t.level;
    tick_bus.cat_near     <= r.t.cat;
    tick_bus.button_step  <= r.t.step;
    tick_bus.button_next  <= r.t.next;
    do @(posedge clk); while (!tick_bus.ready);
    s = predict_status(r.t);
    if (r.chk) begin
      s.mode   = r.mode;
      s.pump   = r.pump;
      s.ind    = r.ind;
      s.cursor = r.cursor;
      s.commit = r.commit;
    end
    pending_status.push_back(s);
    ticks_sent++;
  endtask

  function automatic script_row_t plain_tick(input int lvl, input bit cat, input bit step,
                                             input bit next);
    script_row_t r;
    r = '0;
    r.t.level = level_t'(lvl);
    r.t.cat   = cat;
    r.t.step  = step;
    r.t.next  = next;
    return r;
  endfunction

  // Level readings bunch around the current thresholds, where the mode
  // changes happen, with the two ends of the range and plain random values.
  function automatic int pick_level();
    int r;
    int base;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return (1 << LEVEL_BITS) - 1;
    if (r <= 5) begin
      case ($urandom_range(3))
        0:       base = thr_empty;
        1:       base = thr_low;
        2:       base = thr_leave_low;
        default: base = thr_leave_empty;
      endcase
      base = base + $urandom_range(4) - 2;
      if (base < 0) base = 0;
      if (base > (1 << LEVEL_BITS) - 1) base = (1 << LEVEL_BITS) - 1;
      return base;
    end
    return $urandom_range((1 << LEVEL_BITS) - 1);
  endfunction

  // Gets into clock setting and edits until the commit. Most digits get a
  // few steps; now and then one is stepped far enough to wrap past nine.
  task automatic run_clock_edit();
    int guard;
    int n;
    guard = 0;
    while (fm_mode != MODE_CLOCK && guard < 4) begin
      send_tick(plain_tick($urandom_range(4095), 1'b0, 1'b0, 1'b1));
      guard++;
    end
    while (fm_mode == MODE_CLOCK) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(11) : $urandom_range(2);
      repeat (n) begin
        send_tick(plain_tick($urandom_range(4095), $urandom_range(1), 1'b1,
                             $urandom_range(3) == 0));
      end
      send_tick(plain_tick($urandom_range(4095), $urandom_range(1), 1'b0, 1'b1));
    end
  endtask

  // Lowers valid and waits until every status transfer has come back, plus
  // some settling cycles; thresholds are only touched after this.
  task automatic wait_idle(input int settle);
    tick_bus.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Receiver: ready is redrawn every cycle at the current stall rate.
  initial begin
    status_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      status_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Status checker: each transfer is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && status_bus.valid && status_bus.ready) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] status transfer with no tick waiting for it", $realtime);
        end
      end else begin
        front_status = pending_status.pop_front();
        check_field("mode", 32'(front_status.mode), 32'(status_bus.mode));
        check_field("pump_on", 32'(front_status.pump), 32'(status_bus.pump_on));
        check_field("level_indicator", 32'(front_status.ind),
                    32'(status_bus.level_indicator));
        check_field("drunk_total", front_status.drunk, status_bus.drunk_total);
        check_field("cursor_position", 32'(front_status.cursor),
                    32'(status_bus.cursor_position));
        check_field("time_commit", 32'(front_status.commit), 32'(status_bus.time_commit));
        check_field("seconds_value", 32'(front_status.pairs[0]),
                    32'(status_bus.seconds_value));
        check_field("minutes_value", 32'(front_status.pairs[1]),
                    32'(status_bus.minutes_value));
        check_field("hours_value", 32'(front_status.pairs[2]), 32'(status_bus.hours_value));
        check_field("day_value", 32'(front_status.pairs[3]), 32'(status_bus.day_value));
        check_field("month_value", 32'(front_status.pairs[4]), 32'(status_bus.month_value));
        check_field("year_value", 32'(front_status.pairs[5]), 32'(status_bus.year_value));
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_pet_fountain_level_pump_fsm failed");
      $finish;
    end
  end

  initial begin
    logic [CFG_DATA_BITS-1:0] rd;
    int target;
    int kind;
    int n;
    int lvl;
    int a;
    int b;
    int c;
    int d;

    // Everything driven to a known value from time zero.
    rst_n                 = 1'b0;
    tick_bus.valid        = 1'b0;
    tick_bus.level_sample = '0;
    tick_bus.cat_near     = 1'b0;
    tick_bus.button_step  = 1'b0;
    tick_bus.button_next  = 1'b0;
    cfg_psel              = 1'b0;
    cfg_penable           = 1'b0;
    cfg_pwrite            = 1'b0;
    cfg_paddr             = '0;
    cfg_pwdata            = '0;

    thr_empty       = RESET_THR[REG_EMPTY_THR];
    thr_low         = RESET_THR[REG_LOW_THR];
    thr_leave_low   = RESET_THR[REG_LEAVE_LOW_THR];
    thr_leave_empty = RESET_THR[REG_LEAVE_EMPTY_THR];
    fm_mode         = MODE_NORMAL;
    fm_ret          = MODE_NORMAL;
    fm_start_level  = '0;
    fm_drunk        = '0;
    fm_cursor       = '0;
    fm_ind          = IND_NORMAL;
    fm_pump         = 1'b0;
    foreach (fm_digits[i]) fm_digits[i] = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // The thresholds must come out of reset at their documented values.
    for (int i = 0; i < 4; i++) begin
      apb_cycle(1'b0, reg_index_t'(i), '0, rd);
      check_field("threshold after reset", 32'(RESET_THR[i]), rd);
    end

    // Directed script at the reset thresholds, no idling.
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_tick(DIRECTED_TICKS[i]);
    end
    wait_idle(4);

    // Random phases. Each phase first waits for the block to go quiet, then
    // loads a new set of thresholds and a new idling pattern.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          a = 400; b = 1000; c = 1200; d = 600;
        end
        1: begin
          // Everything at zero: from normal mode, nothing is ever low or empty.
          a = 0; b = 0; c = 0; d = 0;
        end
        2: begin
          // Everything at the top: almost any reading is empty.
          a = 4095; b = 4095; c = 4095; d = 4095;
        end
        3: begin
          // Sensible ordering with random gaps.
          a = $urandom_range(1500);
          b = a + $urandom_range(1000);
          c = b + $urandom_range(800);
          d = a + $urandom_range(c - a);
        end
        4: begin
          // Leave-low below leave-empty, so empty can go straight to normal
          // for readings between the two.
          a = $urandom_range(200, 1000);
          b = a + $urandom_range(800);
          c = a + $urandom_range(50, 400);
          d = c + $urandom_range(1, 1500);
        end
        default: begin
          a = $urandom_range(4095);
          b = $urandom_range(4095);
          c = $urandom_range(4095);
          d = $urandom_range(4095);
        end
      endcase
      write_threshold(REG_EMPTY_THR, level_t'(a));
      write_threshold(REG_LOW_THR, level_t'(b));
      write_threshold(REG_LEAVE_LOW_THR, level_t'(c));
      write_threshold(REG_LEAVE_EMPTY_THR, level_t'(d));

      case (ph)
        0:       begin send_pct = 0;  stall_pct = 0;  end
        1:       begin send_pct = 50; stall_pct = 0;  end
        2:       begin send_pct = 0;  stall_pct = 50; end
        3, 4:    begin send_pct = 13; stall_pct = 13; end
        default: begin send_pct = 50; stall_pct = 50; end
      endcase

      target = N_DIRECTED + (ph + 1) * PHASE_TICKS;
      while (ticks_sent < target) begin
        kind = $urandom_range(99);
        if (kind < 30) begin
          // A drinking visit: cat arrives, level sags a little each tick
          // (sometimes it rises), then the cat leaves.
          lvl = pick_level();
          n = $urandom_range(1, 5);
          send_tick(plain_tick(lvl, 1'b1, $urandom_range(1), 1'b0));
          repeat (n + 1) begin
            lvl = lvl - ($urandom_range(300) - 50);
            if (lvl < 0) lvl = 0;
            if (lvl > 4095) lvl = 4095;
            send_tick(plain_tick(lvl, 1'b1, $urandom_range(1), 1'b0));
          end
          send_tick(plain_tick(lvl, 1'b0, $urandom_range(1), 1'b0));
        end else if (kind < 60) begin
          // Level wandering around the thresholds with the odd cat.
          n = $urandom_range(1, 8);
          repeat (n) begin
            send_tick(plain_tick(pick_level(), $urandom_range(3) == 0,
                                 $urandom_range(1), 1'b0));
          end
        end else if (kind < 72) begin
          run_clock_edit();
        end else begin
          // Noise: anything goes, button B now and then. A stray B press
          // lands in clock setting, which is then finished off.
          n = $urandom_range(1, 5);
          repeat (n) begin
            send_tick(plain_tick($urandom_range(4095), $urandom_range(1),
                                 $urandom_range(1), $urandom_range(9) == 0));
          end
          if (fm_mode == MODE_CLOCK) run_clock_edit();
        end
      end
      wait_idle(4);
    end

    wait_idle(10);
    if (mismatches == 0) begin
      $display("tb_pet_fountain_level_pump_fsm passed");
    end else begin
      $display("tb_pet_fountain_level_pump_fsm failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/pflp_pkg.sv
rtl/pflp_in_if.sv
rtl/pflp_out_if.sv
rtl/pet_fountain_level_pump_fsm.sv
test/tb_pet_fountain_level_pump_fsm.sv
